// ===== design/css_pkg.sv =====
`default_nettype none
package css_pkg;
   localparam int ElemWidth = 16;
   localparam int DotWidth = 42;
   localparam int NormWidth = 41;
   localparam int RootWidth = 21;
   localparam int DenWidth = 42;
   localparam int QuoWidth = 57;
   localparam int MaxVectorLength = 1024;
   localparam logic [31:0] FloorReset = 32'd1074;
   localparam logic [0:0] RegFloor = 1'b0;
   localparam logic [1:0] AddrFloor = 2'(4 * RegFloor);
endpackage
`default_nettype wire

// ===== design/css_if.sv =====
`default_nettype none
interface css_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] elem_a;
   logic signed [15:0] elem_b;
   logic has_pair;
   logic last;
   modport source (output valid, elem_a, elem_b, has_pair, last, input ready);
   modport sink (input valid, elem_a, elem_b, has_pair, last, output ready);
endinterface

interface css_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] similarity;
   logic degenerate;
   modport source (output valid, similarity, degenerate, input ready);
   modport sink (input valid, similarity, degenerate, output ready);
endinterface
`default_nettype wire

// ===== design/cosine_similarity_stream_top.sv =====
// Streaming cosine similarity of two Q1.15 vectors.
// The req channel carries one element pair per item (elem_a, elem_b, has_pair,
// last). Pairs with has_pair set are accumulated into the dot product and the
// two squared norms, saturating at the accumulator widths. An item with last
// set closes the vector and causes one item on the rsp channel: similarity in
// Q1.15, saturated to [-1, 1), and degenerate when the norm product falls
// below the floor register (or is zero), in which case similarity is 0.
// Flow: an item with neither a pair nor last leaves the sequencer idle, so req
// ready stays high. A pair item that is not last keeps req ready low after it
// is taken while the sequencer steps through S_MUL_D, S_MUL_A, S_MUL_B and
// S_ACC: three products through the one shared multiplier, then the final
// saturating accumulate. So no new pair is taken before that one is through.
// After an item with last set come the accumulate (if it carries a pair), two
// 21-step square roots sharing one shift-subtract unit, the root product, the
// floor check, a 57-step restoring divide and the step that sets rsp valid.
// The result sits in an output register and req ready stays low until it is
// taken, so a stalled receiver holds the block; the next item can be taken in
// the cycle after. Reset (synchronous, active high) clears the accumulators,
// the sequencer and the output valid, and sets denominator_floor to 1074. The
// floor register is written over the csr port at byte address 0.
`default_nettype none
module cosine_similarity_stream_top (
   input  wire logic        clock,
   input  wire logic        reset,
   css_req_if.sink          req,
   css_rsp_if.source        rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import css_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_MUL_D = 4'd1, S_MUL_A = 4'd2,
      S_MUL_B = 4'd3, S_ACC = 4'd4, S_SQA = 4'd5, S_SQB = 4'd6,
      S_DEN = 4'd7, S_CHK = 4'd8, S_DIV = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;
   localparam int CntWidth = $clog2(QuoWidth + 1);
   localparam logic signed [DotWidth:0] DotSatHi = {2'b00, {(DotWidth-1){1'b1}}};
   localparam logic signed [DotWidth:0] DotSatLo = {2'b11, {(DotWidth-1){1'b0}}};

   logic [3:0] state_ff, state_in;
   logic [31:0] floor_ff;
   logic signed [15:0] a_ff, b_ff;
   logic last_ff;
   logic signed [DotWidth-1:0] dot_ff;
   logic [NormWidth-1:0] na_ff, nb_ff;
   logic signed [32:0] prod_ff;
   logic [DenWidth-1:0] rem_ff;
   logic [RootWidth-1:0] root_ff, ra_ff;
   logic [DenWidth-1:0] den_ff;
   logic [QuoWidth-1:0] num_ff, quo_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic neg_ff;
   logic signed [15:0] sim_ff;
   logic degen_ff, ovalid_ff;

   // The shared multiplier, operands picked by the sequencer.
   logic signed [21:0] mul_x, mul_y;
   logic signed [43:0] mul_p;
   always_comb begin
      mul_x = 22'sd0;
      mul_y = 22'sd0;
      case (state_ff)
         S_MUL_D: begin mul_x = 22'(a_ff); mul_y = 22'(b_ff); end
         S_MUL_A: begin mul_x = 22'(a_ff); mul_y = 22'(a_ff); end
         S_MUL_B: begin mul_x = 22'(b_ff); mul_y = 22'(b_ff); end
         S_DEN: begin
            mul_x = $signed({1'b0, ra_ff});
            mul_y = $signed({1'b0, root_ff});
         end
         default: ;
      endcase
      mul_p = mul_x * mul_y;
   end

   // Saturating accumulate of one product.
   logic signed [DotWidth:0] dot_sum;
   logic [NormWidth:0] norm_sum;
   always_comb begin
      dot_sum = (DotWidth+1)'(dot_ff) + (DotWidth+1)'(prod_ff);
      norm_sum = {1'b0, (state_ff == S_MUL_B) ? na_ff : nb_ff} +
                 (NormWidth+1)'($unsigned(prod_ff[31:0]));
   end

   // Bitwise square root step: one result bit per cycle, two radicand bits.
   logic [NormWidth:0] sq_src;
   logic [RootWidth+1:0] sq_trial;
   logic [RootWidth+1:0] sq_test;
   logic [RootWidth-1:0] sq_root_next;
   logic [DenWidth-1:0] sq_rem_next;
   always_comb begin
      sq_src = {1'b0, (state_ff == S_SQA) ? na_ff : nb_ff};
      sq_trial = 23'({rem_ff[RootWidth:0], 2'b00}) |
                 23'(sq_src[2*(cnt_ff[4:0])+:2]);
      sq_test = {root_ff, 2'b01};
      if (sq_trial >= sq_test) begin
         sq_rem_next = DenWidth'(sq_trial - sq_test);
         sq_root_next = {root_ff[RootWidth-2:0], 1'b1};
      end else begin
         sq_rem_next = DenWidth'(sq_trial);
         sq_root_next = {root_ff[RootWidth-2:0], 1'b0};
      end
   end

   // Restoring divide step.
   logic [DenWidth:0] dv_rem;
   always_comb dv_rem = {rem_ff, num_ff[QuoWidth-1]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req.valid && req.ready) begin
            state_in = req.has_pair ? S_MUL_D : (req.last ? S_SQA : S_IDLE);
         end
         S_MUL_D: state_in = S_MUL_A;
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: state_in = S_ACC;
         S_ACC: state_in = last_ff ? S_SQA : S_IDLE;
         S_SQA: if (cnt_ff == '0) state_in = S_SQB;
         S_SQB: if (cnt_ff == '0) state_in = S_DEN;
         S_DEN: state_in = S_CHK;
         S_CHK: state_in = S_DIV;
         S_DIV: if (cnt_ff == '0) state_in = S_FIN;
         S_FIN: state_in = S_OUT;
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         floor_ff <= FloorReset;
         dot_ff <= '0;
         na_ff <= '0;
         nb_ff <= '0;
         ovalid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == AddrFloor)
            floor_ff <= csr_pwdata;
         case (state_ff)
            S_IDLE: begin
               a_ff <= req.elem_a;
               b_ff <= req.elem_b;
               last_ff <= req.last;
               rem_ff <= '0;
               root_ff <= '0;
               cnt_ff <= CntWidth'(RootWidth - 1);
            end
            S_MUL_D: prod_ff <= 33'(mul_p);
            S_MUL_A: begin
               if (dot_sum > DotSatHi) dot_ff <= DotSatHi[DotWidth-1:0];
               else if (dot_sum < DotSatLo) dot_ff <= DotSatLo[DotWidth-1:0];
               else dot_ff <= DotWidth'(dot_sum);
               prod_ff <= 33'(mul_p);
            end
            S_MUL_B: begin
               na_ff <= norm_sum[NormWidth] ? '1 : norm_sum[NormWidth-1:0];
               prod_ff <= 33'(mul_p);
            end
            S_ACC: begin
               nb_ff <= norm_sum[NormWidth] ? '1 : norm_sum[NormWidth-1:0];
               rem_ff <= '0;
               root_ff <= '0;
               cnt_ff <= CntWidth'(RootWidth - 1);
            end
            S_SQA, S_SQB: begin
               // The first root is parked in ra_ff and the unit restarts.
               if (state_ff == S_SQA && cnt_ff == '0) begin
                  ra_ff <= sq_root_next;
                  rem_ff <= '0;
                  root_ff <= '0;
               end else begin
                  rem_ff <= sq_rem_next;
                  root_ff <= sq_root_next;
               end
               if (cnt_ff == '0) cnt_ff <= CntWidth'(RootWidth - 1);
               else cnt_ff <= cnt_ff - 1'b1;
            end
            S_DEN: begin
               den_ff <= DenWidth'($unsigned(mul_p));
               neg_ff <= dot_ff[DotWidth-1];
            end
            S_CHK: begin
               degen_ff <= (den_ff == '0) || (den_ff < DenWidth'(floor_ff));
               num_ff <= QuoWidth'({(dot_ff[DotWidth-1] ? -dot_ff : dot_ff), 15'd0}) +
                         QuoWidth'(den_ff >> 1);
               rem_ff <= '0;
               cnt_ff <= CntWidth'(QuoWidth - 1);
            end
            S_DIV: begin
               if (dv_rem >= {1'b0, den_ff}) begin
                  rem_ff <= DenWidth'(dv_rem - {1'b0, den_ff});
                  quo_ff <= {quo_ff[QuoWidth-2:0], 1'b1};
               end else begin
                  rem_ff <= DenWidth'(dv_rem);
                  quo_ff <= {quo_ff[QuoWidth-2:0], 1'b0};
               end
               num_ff <= {num_ff[QuoWidth-2:0], 1'b0};
               if (cnt_ff != '0) cnt_ff <= cnt_ff - 1'b1;
            end
            S_FIN: begin
               if (degen_ff) sim_ff <= 16'sd0;
               else if (neg_ff) sim_ff <= (quo_ff > QuoWidth'(32768)) ? -16'sd32768
                                          : 16'(-quo_ff);
               else sim_ff <= (quo_ff > QuoWidth'(32767)) ? 16'sd32767 : 16'(quo_ff);
               dot_ff <= '0;
               na_ff <= '0;
               nb_ff <= '0;
               ovalid_ff <= 1'b1;
            end
            S_OUT: if (rsp.ready) ovalid_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.similarity = sim_ff;
   assign rsp.degenerate = degen_ff;
   assign csr_prdata = floor_ff;
   assign csr_pready = 1'b1;

   a_out_in_state: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff |-> state_ff == S_OUT) else $error("rsp valid outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff |-> !req.ready) else $error("req ready while result pending");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && degen_ff) |-> sim_ff == 16'sd0) else $error("degenerate nonzero");
endmodule
`default_nettype wire

// ===== bench/cosine_similarity_stream_top_test.sv =====
`timescale 1ns / 1ps
module cosine_similarity_stream_top_test;
   import css_pkg::*;

   localparam logic [41:0] DotMax = {1'b0, {41{1'b1}}};
   localparam logic [41:0] DotMin = {1'b1, {41{1'b0}}};
   localparam logic [40:0] NormMax = {41{1'b1}};

   typedef struct packed {
      logic signed [15:0] similarity;
      logic degenerate;
   } sim_result_type;

   typedef struct {
      logic signed [15:0] elem_a;
      logic signed [15:0] elem_b;
      logic has_pair;
      logic last;
      logic known;
      logic signed [15:0] similarity;
      logic degenerate;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   css_req_if req ();
   css_rsp_if rsp ();

   cosine_similarity_stream_top u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Predictor state, mirroring the accumulators and the floor register.
   logic [31:0] floor_reg;
   logic signed [41:0] dot_sum;
   logic [40:0] norm_a_sum;
   logic [40:0] norm_b_sum;
   sim_result_type pending_results[$];
   int errors = 0;
   int results_seen = 0;
   int vectors_sent = 0;
   int items_sent = 0;
   int hold_cycles = 0;
   bit idle_on = 1'b1;
   bit sender_done = 1'b0;

   function automatic logic [20:0] floor_root(logic [40:0] n);
      logic [41:0] rem;
      logic [41:0] root;
      logic [41:0] bitv;
      rem = {1'b0, n};
      root = '0;
      bitv = 42'd1 << 40;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[20:0];
   endfunction

   // Accumulate one pair; on last, compute the similarity and clear the sums.
   function automatic bit cosine_step(logic signed [15:0] ea, logic signed [15:0] eb,
                                      logic hp, logic lst, output sim_result_type res);
      logic signed [63:0] d;
      logic [63:0] na;
      logic [63:0] nb;
      logic [63:0] den;
      logic [63:0] mag;
      logic [63:0] q;
      bit neg;
      if (hp) begin
         d = 64'(dot_sum) + 64'(ea) * 64'(eb);
         na = 64'(norm_a_sum) + 64'(64'(ea) * 64'(ea));
         nb = 64'(norm_b_sum) + 64'(64'(eb) * 64'(eb));
         if (d > $signed(64'(signed'(DotMax)))) d = 64'(signed'(DotMax));
         if (d < $signed(64'(signed'(DotMin)))) d = 64'(signed'(DotMin));
         if (na > 64'(NormMax)) na = 64'(NormMax);
         if (nb > 64'(NormMax)) nb = 64'(NormMax);
         dot_sum = d[41:0];
         norm_a_sum = na[40:0];
         norm_b_sum = nb[40:0];
      end
      if (!lst) return 1'b0;
      den = 64'(floor_root(norm_a_sum)) * 64'(floor_root(norm_b_sum));
      res.similarity = '0;
      res.degenerate = 1'b0;
      if (den == 0 || den < 64'(floor_reg)) begin
         res.degenerate = 1'b1;
      end else begin
         neg = dot_sum < 0;
         mag = neg ? 64'(-64'(dot_sum)) : 64'(dot_sum);
         q = ((mag << 15) + (den >> 1)) / den;
         if (neg) res.similarity = (q > 32768) ? -16'sd32768 : 16'(-q);
         else res.similarity = (q > 32767) ? 16'sd32767 : 16'(q);
      end
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      return 1'b1;
   endfunction

   initial begin
      req.valid = 1'b0;
      req.elem_a = '0;
      req.elem_b = '0;
      req.has_pair = 1'b0;
      req.last = 1'b0;
      rsp.ready = 1'b0;
   end

   // Receiver: random stall bursts, a long hold-off on request, none at the end.
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            rsp.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      sim_result_type exp_res;
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result with no expectation: similarity %0d", rsp.similarity);
            errors++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp.similarity !== exp_res.similarity) begin
               $error("similarity expected %0d actual %0d",
                      exp_res.similarity, rsp.similarity);
               errors++;
            end
            if (rsp.degenerate !== exp_res.degenerate) begin
               $error("degenerate expected %0b actual %0b",
                      exp_res.degenerate, rsp.degenerate);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= AddrFloor;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      floor_reg = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_check(logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr <= AddrFloor;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $error("denominator_floor expected %0d actual %0d", value, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Wait until all expected results arrived, then keep the clock running a while.
   task automatic drain();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // Send one item; the caller runs in the negedge phase.
   task automatic send_item(logic signed [15:0] ea, logic signed [15:0] eb,
                            logic hp, logic lst, bit gaps);
      sim_result_type res;
      int gap;
      if (gaps && idle_on && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 19);
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.elem_a <= ea;
      req.elem_b <= eb;
      req.has_pair <= hp;
      req.last <= lst;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (cosine_step(ea, eb, hp, lst, res)) begin
         pending_results = {pending_results, res};
         vectors_sent++;
      end
      items_sent++;
      @(negedge clock);
   endtask

   // One vector of random length and a chosen content style.
   task automatic send_vector(int len, bit gaps);
      int style;
      logic signed [15:0] ea;
      logic signed [15:0] eb;
      style = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         ea = 16'($urandom);
         eb = 16'($urandom);
         case (style)
            0: begin
               eb = ea;
            end
            1: begin
               eb = (ea == -16'sd32768) ? 16'sd32767 : -ea;
            end
            2: begin
               ea = 16'($signed($urandom_range(0, 15)) - 8);
               eb = 16'($signed($urandom_range(0, 15)) - 8);
            end
            3: begin
               eb = ea + 16'($signed($urandom_range(0, 63)) - 32);
            end
            default: begin
            end
         endcase
         if ($urandom_range(0, 19) == 0)
            send_item(16'($urandom), 16'($urandom), 1'b0, 1'b0, gaps);
         if (i == len - 1 && $urandom_range(0, 4) == 0) begin
            send_item(ea, eb, 1'b1, 1'b0, gaps);
            send_item(16'($urandom), 16'($urandom), 1'b0, 1'b1, gaps);
         end else begin
            send_item(ea, eb, 1'b1, i == len - 1, gaps);
         end
      end
   endtask

   initial begin
      stim_row_type rows[16];
      sim_result_type res;
      int len;
      int cnt;

      floor_reg = FloorReset;
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check(FloorReset);

      // Directed table: known results where they are obvious.
      rows = '{
         '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1, 16'sd0, 1'b1},
         '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1, 16'sd0, 1'b1},
         '{16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b1, 16'sd32767, 1'b0},
         '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 1'b1, 16'sd32767, 1'b0},
         '{-16'sd32768, 16'sd32767, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0},
         '{16'sd32767, -16'sd32768, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0},
         '{16'sd1234, -16'sd77, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
         '{16'sd1000, 16'sd0, 1'b1, 1'b1, 1'b1, 16'sd0, 1'b1},
         '{16'sd1, 16'sd1, 1'b1, 1'b1, 1'b1, 16'sd0, 1'b1},
         '{16'sd300, 16'sd200, 1'b1, 1'b0, 1'b0, 16'sd0, 1'b0},
         '{16'sd100, -16'sd50, 1'b1, 1'b0, 1'b0, 16'sd0, 1'b0},
         '{-16'sd1, 16'sd0, 1'b0, 1'b1, 1'b0, 16'sd0, 1'b0},
         '{16'sd3, 16'sd4, 1'b1, 1'b0, 1'b0, 16'sd0, 1'b0},
         '{16'sd4, 16'sd3, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0},
         '{16'sd21845, -16'sd10923, 1'b1, 1'b0, 1'b0, 16'sd0, 1'b0},
         '{-16'sd21846, 16'sd10922, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0}
      };
      foreach (rows[i]) begin
         send_item(rows[i].elem_a, rows[i].elem_b, rows[i].has_pair, rows[i].last, 1'b0);
         if (rows[i].known && rows[i].last) begin
            res = pending_results[$];
            if (res.similarity !== rows[i].similarity) begin
               $error("table row %0d similarity expected %0d actual %0d", i,
                      rows[i].similarity, res.similarity);
               errors++;
            end
            if (res.degenerate !== rows[i].degenerate) begin
               $error("table row %0d degenerate expected %0b actual %0b", i,
                      rows[i].degenerate, res.degenerate);
               errors++;
            end
         end
      end
      req.valid <= 1'b0;
      drain();

      // Floor of zero: a unit denominator is real, an empty vector is not.
      csr_write(32'd0);
      csr_check(32'd0);
      send_item(16'sd1, 16'sd1, 1'b1, 1'b1, 1'b0);
      send_item(16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0);
      send_item(-16'sd1, 16'sd1, 1'b1, 1'b1, 1'b0);
      req.valid <= 1'b0;
      drain();

      // Random phases, each under its own floor setting.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: csr_write(32'hFFFF_FFFF);
            1: csr_write(FloorReset);
            2: csr_write($urandom_range(0, 32'h3FFF_FFFF));
            default: csr_write(32'd1 << $urandom_range(0, 31));
         endcase
         cnt = 0;
         while (cnt < 60) begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            if (phase == 1 && cnt == 10) hold_cycles = 600;
            if (phase == 3 && cnt > 30) idle_on = 1'b0;
            if (len == 0) send_item(16'($urandom), 16'($urandom), 1'b0, 1'b1, 1'b1);
            else send_vector(len, 1'b1);
            cnt++;
         end
         // The sender pauses until every expected result has come.
         req.valid <= 1'b0;
         drain();
      end

      idle_on = 1'b1;
      csr_write(32'd7);
      req.valid <= 1'b0;
      drain();
      $display("Sent %0d items closing %0d vectors; %0d results checked.",
               items_sent, vectors_sent, results_seen);
      $display("Floors covered zero, reset value, all ones and random values.");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
